FILE: rtl/hsv_pixel_frame_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// HSV pixel frame generator - assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef HSV_PIXEL_FRAME_GENERATOR_UNIT_DEFINES_SVH
`define HSV_PIXEL_FRAME_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at each rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked at each rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/hsvpfg_pkg.sv
// ----------------------------------------------------------------------------
// HSV pixel frame generator - shared package
// Control word layout, register selectors, constants and the microprogram.
// ----------------------------------------------------------------------------
package hsvpfg_pkg;

    // Field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;
    localparam int IDX_W = 6;
    localparam int OP_W  = 15;   // largest intermediate is 100 * 255
    localparam int KB_W  = 17;
    localparam int SH_W  = 5;
    localparam int PC_W  = 5;
    localparam int PROD_W = OP_W + KB_W;

    // Clamp limits and tick colour
    localparam logic [HUE_W-1:0] HUE_MAX  = 9'd359;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [PCT_W-1:0] TICK_SAT = 7'd80;
    localparam logic [PCT_W-1:0] TICK_VAL = 7'd4;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;

    // Division by constants as multiply and shift; each is exact over its operand range
    localparam logic [KB_W-1:0] K_DIV60   = 17'd1093;   // hue / 60, hue <= 359
    localparam logic [SH_W-1:0] SH_DIV60  = 5'd16;
    localparam logic [KB_W-1:0] K_SPAN    = 17'd60;
    localparam logic [KB_W-1:0] K_REM     = 17'd17;     // x * 255 / 60 == x * 17 / 4
    localparam logic [SH_W-1:0] SH_REM    = 5'd2;
    localparam logic [KB_W-1:0] K_DIV255  = 17'd65794;  // x / 255, x <= 25500
    localparam logic [SH_W-1:0] SH_DIV255 = 5'd24;
    localparam logic [KB_W-1:0] K_DIV100  = 17'd41944;  // x / 100, x <= 25500
    localparam logic [SH_W-1:0] SH_DIV100 = 5'd22;
    localparam logic [KB_W-1:0] K_SCALE   = 17'd10445;  // x * 255 / 100, x <= 100
    localparam logic [SH_W-1:0] SH_SCALE  = 5'd12;
    localparam logic [KB_W-1:0] K_NONE    = 17'd0;
    localparam logic [SH_W-1:0] SH_NONE   = 5'd0;

    typedef enum logic [3:0] {
        R_ZERO, R_HUE, R_SAT, R_VAL, R_REGION, R_REM, R_T1,
        R_P, R_Q, R_T, R_V, R_K100, R_K255
    } reg_sel_t;

    typedef enum logic [2:0] {
        FL_NEXT, FL_WAIT_IN, FL_LOAD, FL_EMIT, FL_JUMP_TICK, FL_JUMP
    } flow_t;

    typedef struct packed {
        flow_t            flow;
        logic [PC_W-1:0]  target;
        logic             wr_en;
        reg_sel_t         dst;
        reg_sel_t         src_a;
        reg_sel_t         src_s;   // subtracted from src_a
        logic             b_is_k;
        reg_sel_t         src_b;
        logic [KB_W-1:0]  k_b;
        logic [SH_W-1:0]  shamt;
    } uword_t;

    typedef struct packed {
        logic             accept;
        logic             load;
        logic             emit;
        logic             tick;
        logic             last;
        logic [IDX_W-1:0] pix_idx;
        uword_t           uw;
    } seq_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_LOAD = 5'd1;
    localparam logic [PC_W-1:0] PC_EMIT = 5'd19;

    function automatic uword_t flow_step(flow_t fl, logic [PC_W-1:0] tgt);
        uword_t w;
        w        = '0;
        w.flow   = fl;
        w.target = tgt;
        w.dst    = R_ZERO;
        w.src_a  = R_ZERO;
        w.src_s  = R_ZERO;
        w.src_b  = R_ZERO;
        return w;
    endfunction

    // dst = ((a - s) * b) >> sh, b a register or a constant
    function automatic uword_t alu_step(reg_sel_t dst, reg_sel_t a, reg_sel_t s,
                                        logic b_is_k, reg_sel_t b,
                                        logic [KB_W-1:0] k, logic [SH_W-1:0] sh);
        uword_t w;
        w        = '0;
        w.flow   = FL_NEXT;
        w.wr_en  = 1'b1;
        w.dst    = dst;
        w.src_a  = a;
        w.src_s  = s;
        w.b_is_k = b_is_k;
        w.src_b  = b;
        w.k_b    = k;
        w.shamt  = sh;
        return w;
    endfunction

    // Microprogram: one pixel conversion, then emit and loop
    function automatic uword_t ucode_word(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:  w = flow_step(FL_WAIT_IN, PC_IDLE);
            5'd1:  w = flow_step(FL_LOAD, PC_IDLE);
            5'd2:  w = alu_step(R_REGION, R_HUE, R_ZERO, 1'b1, R_ZERO, K_DIV60, SH_DIV60);
            5'd3:  w = alu_step(R_T1, R_REGION, R_ZERO, 1'b1, R_ZERO, K_SPAN, SH_NONE);
            5'd4:  w = alu_step(R_REM, R_HUE, R_T1, 1'b1, R_ZERO, K_REM, SH_REM);
            // q
            5'd5:  w = alu_step(R_T1, R_SAT, R_ZERO, 1'b0, R_REM, K_NONE, SH_NONE);
            5'd6:  w = alu_step(R_T1, R_T1, R_ZERO, 1'b1, R_ZERO, K_DIV255, SH_DIV255);
            5'd7:  w = alu_step(R_T1, R_K100, R_T1, 1'b0, R_VAL, K_NONE, SH_NONE);
            5'd8:  w = alu_step(R_T1, R_T1, R_ZERO, 1'b1, R_ZERO, K_DIV100, SH_DIV100);
            5'd9:  w = alu_step(R_Q, R_T1, R_ZERO, 1'b1, R_ZERO, K_SCALE, SH_SCALE);
            // t
            5'd10: w = alu_step(R_T1, R_K255, R_REM, 1'b0, R_SAT, K_NONE, SH_NONE);
            5'd11: w = alu_step(R_T1, R_T1, R_ZERO, 1'b1, R_ZERO, K_DIV255, SH_DIV255);
            5'd12: w = alu_step(R_T1, R_K100, R_T1, 1'b0, R_VAL, K_NONE, SH_NONE);
            5'd13: w = alu_step(R_T1, R_T1, R_ZERO, 1'b1, R_ZERO, K_DIV100, SH_DIV100);
            5'd14: w = alu_step(R_T, R_T1, R_ZERO, 1'b1, R_ZERO, K_SCALE, SH_SCALE);
            // p
            5'd15: w = alu_step(R_T1, R_K100, R_SAT, 1'b0, R_VAL, K_NONE, SH_NONE);
            5'd16: w = alu_step(R_T1, R_T1, R_ZERO, 1'b1, R_ZERO, K_DIV100, SH_DIV100);
            5'd17: w = alu_step(R_P, R_T1, R_ZERO, 1'b1, R_ZERO, K_SCALE, SH_SCALE);
            // v
            5'd18: w = alu_step(R_V, R_VAL, R_ZERO, 1'b1, R_ZERO, K_SCALE, SH_SCALE);
            5'd19: w = flow_step(FL_EMIT, PC_IDLE);
            5'd20: w = flow_step(FL_JUMP_TICK, PC_LOAD);
            5'd21: w = flow_step(FL_JUMP, PC_EMIT);
            default: w = flow_step(FL_JUMP, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/hsvpfg_sequencer.sv
// ----------------------------------------------------------------------------
// HSV pixel frame generator - microcode sequencer
// Step counter over the control store, request intake and pixel counting.
// ----------------------------------------------------------------------------
module hsvpfg_sequencer #(
    parameter int PIXEL_COUNT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_tick,
    input  logic                 slot_free,
    output logic                 in_ready,
    output hsvpfg_pkg::seq_ctl_t ctl
);

    localparam logic [hsvpfg_pkg::IDX_W-1:0] LAST_IDX =
        hsvpfg_pkg::IDX_W'(PIXEL_COUNT - 1);

    logic [hsvpfg_pkg::PC_W-1:0]  pc_reg,  pc_next;
    logic [hsvpfg_pkg::IDX_W-1:0] pix_reg, pix_next;
    logic                         tick_reg, tick_next;
    hsvpfg_pkg::uword_t           uw;
    logic                         last;

    assign uw   = hsvpfg_pkg::ucode_word(pc_reg);
    assign last = (pix_reg == LAST_IDX);

    always_comb begin
        pc_next     = pc_reg + 1'b1;
        pix_next    = pix_reg;
        tick_next   = tick_reg;
        in_ready    = 1'b0;
        ctl         = '0;
        ctl.uw      = uw;
        ctl.tick    = tick_reg;
        ctl.last    = last;
        ctl.pix_idx = pix_reg;
        case (uw.flow)
            hsvpfg_pkg::FL_WAIT_IN: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.accept = 1'b1;
                    tick_next  = in_tick;
                    pix_next   = '0;
                end else begin
                    pc_next = pc_reg;
                end
            end
            hsvpfg_pkg::FL_LOAD: begin
                ctl.load = 1'b1;
            end
            hsvpfg_pkg::FL_EMIT: begin
                if (slot_free) begin
                    ctl.emit = 1'b1;
                    if (last) begin
                        pc_next  = hsvpfg_pkg::PC_IDLE;
                        pix_next = '0;
                    end else begin
                        pix_next = pix_reg + 1'b1;
                    end
                end else begin
                    pc_next = pc_reg;
                end
            end
            hsvpfg_pkg::FL_JUMP_TICK: begin
                if (tick_reg) begin
                    pc_next = uw.target;
                end
            end
            hsvpfg_pkg::FL_JUMP: begin
                pc_next = uw.target;
            end
            hsvpfg_pkg::FL_NEXT: begin
                pc_next = pc_reg + 1'b1;
            end
            default: begin
                pc_next = hsvpfg_pkg::PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= hsvpfg_pkg::PC_IDLE;
            pix_reg  <= '0;
            tick_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            pix_reg  <= pix_next;
            tick_reg <= tick_next;
        end
    end

endmodule

FILE: rtl/hsvpfg_datapath.sv
// ----------------------------------------------------------------------------
// HSV pixel frame generator - conversion datapath
// Working registers, one shared multiply-shift unit and the region mux.
// ----------------------------------------------------------------------------
module hsvpfg_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hsvpfg_pkg::seq_ctl_t               ctl,
    input  logic [hsvpfg_pkg::HUE_W-1:0]       in_hue,
    input  logic [hsvpfg_pkg::PCT_W-1:0]       in_sat,
    input  logic [hsvpfg_pkg::PCT_W-1:0]       in_val,
    output hsvpfg_pkg::pixel_t                 pix
);

    logic [hsvpfg_pkg::HUE_W-1:0]  running_hue_reg, running_hue_next;
    logic [hsvpfg_pkg::HUE_W-1:0]  hue_reg;
    logic [hsvpfg_pkg::PCT_W-1:0]  sat_reg, val_reg;
    logic [2:0]                    region_reg;
    logic [hsvpfg_pkg::CH_W-1:0]   rem_reg, p_reg, q_reg, t_reg, v_reg;
    logic [hsvpfg_pkg::OP_W-1:0]   t1_reg;

    logic [hsvpfg_pkg::OP_W-1:0]   op_a, op_s, op_bv, op_diff;
    logic [hsvpfg_pkg::KB_W-1:0]   op_b;
    logic [hsvpfg_pkg::PROD_W-1:0] prod, res;

    function automatic logic [hsvpfg_pkg::OP_W-1:0] pick(
        hsvpfg_pkg::reg_sel_t sel,
        logic [hsvpfg_pkg::HUE_W-1:0] h, logic [hsvpfg_pkg::PCT_W-1:0] s,
        logic [hsvpfg_pkg::PCT_W-1:0] v, logic [2:0] rg,
        logic [hsvpfg_pkg::CH_W-1:0] rm, logic [hsvpfg_pkg::OP_W-1:0] t1
    );
        logic [hsvpfg_pkg::OP_W-1:0] o;
        case (sel)
            hsvpfg_pkg::R_HUE:    o = hsvpfg_pkg::OP_W'(h);
            hsvpfg_pkg::R_SAT:    o = hsvpfg_pkg::OP_W'(s);
            hsvpfg_pkg::R_VAL:    o = hsvpfg_pkg::OP_W'(v);
            hsvpfg_pkg::R_REGION: o = hsvpfg_pkg::OP_W'(rg);
            hsvpfg_pkg::R_REM:    o = hsvpfg_pkg::OP_W'(rm);
            hsvpfg_pkg::R_T1:     o = t1;
            hsvpfg_pkg::R_K100:   o = hsvpfg_pkg::OP_W'(hsvpfg_pkg::PCT_MAX);
            hsvpfg_pkg::R_K255:   o = hsvpfg_pkg::OP_W'(hsvpfg_pkg::CH_MAX);
            default:              o = '0;
        endcase
        return o;
    endfunction

    // Shared multiply-shift unit
    always_comb begin
        op_a    = pick(ctl.uw.src_a, hue_reg, sat_reg, val_reg, region_reg, rem_reg, t1_reg);
        op_s    = pick(ctl.uw.src_s, hue_reg, sat_reg, val_reg, region_reg, rem_reg, t1_reg);
        op_bv   = pick(ctl.uw.src_b, hue_reg, sat_reg, val_reg, region_reg, rem_reg, t1_reg);
        op_diff = op_a - op_s;
        op_b    = ctl.uw.b_is_k ? ctl.uw.k_b : hsvpfg_pkg::KB_W'(op_bv);
        prod    = hsvpfg_pkg::PROD_W'(op_diff) * hsvpfg_pkg::PROD_W'(op_b);
        res     = prod >> ctl.uw.shamt;
    end

    assign running_hue_next = (running_hue_reg >= hsvpfg_pkg::HUE_MAX) ?
                              '0 : running_hue_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_hue_reg <= '0;
        end else if (ctl.load && ctl.tick) begin
            running_hue_reg <= running_hue_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            hue_reg <= (in_hue > hsvpfg_pkg::HUE_MAX) ? hsvpfg_pkg::HUE_MAX : in_hue;
            sat_reg <= (in_sat > hsvpfg_pkg::PCT_MAX) ? hsvpfg_pkg::PCT_MAX : in_sat;
            val_reg <= (in_val > hsvpfg_pkg::PCT_MAX) ? hsvpfg_pkg::PCT_MAX : in_val;
        end else if (ctl.load && ctl.tick) begin
            hue_reg <= running_hue_next;
            sat_reg <= hsvpfg_pkg::TICK_SAT;
            val_reg <= hsvpfg_pkg::TICK_VAL;
        end
        if (ctl.uw.wr_en) begin
            case (ctl.uw.dst)
                hsvpfg_pkg::R_REGION: region_reg <= res[2:0];
                hsvpfg_pkg::R_REM:    rem_reg    <= res[hsvpfg_pkg::CH_W-1:0];
                hsvpfg_pkg::R_T1:     t1_reg     <= res[hsvpfg_pkg::OP_W-1:0];
                hsvpfg_pkg::R_P:      p_reg      <= res[hsvpfg_pkg::CH_W-1:0];
                hsvpfg_pkg::R_Q:      q_reg      <= res[hsvpfg_pkg::CH_W-1:0];
                hsvpfg_pkg::R_T:      t_reg      <= res[hsvpfg_pkg::CH_W-1:0];
                hsvpfg_pkg::R_V:      v_reg      <= res[hsvpfg_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Route v, p, q, t by hue region; region five and up take the last case
    always_comb begin
        case (region_reg)
            3'd0:    pix = '{red: v_reg, green: t_reg, blue: p_reg};
            3'd1:    pix = '{red: q_reg, green: v_reg, blue: p_reg};
            3'd2:    pix = '{red: p_reg, green: v_reg, blue: t_reg};
            3'd3:    pix = '{red: p_reg, green: q_reg, blue: v_reg};
            3'd4:    pix = '{red: t_reg, green: p_reg, blue: v_reg};
            default: pix = '{red: v_reg, green: p_reg, blue: q_reg};
        endcase
    end

endmodule

FILE: rtl/hsv_pixel_frame_generator_unit.sv
// ----------------------------------------------------------------------------
// HSV pixel frame generator - top level
// Turns each request into one frame of PIXEL_COUNT RGB pixel transactions.
// ----------------------------------------------------------------------------
// Flow: a request is taken only while idle, loaded, converted by the microcode steps, then emitted.
// Frame: a solid frame converts once and re-emits that pixel; a rainbow tick converts each pixel,
//   paced by the single multiply-shift unit taking one microcode step per cycle unless an emit stalls.
// Reset: synchronous, active low; clears the step counter, pixel counter, running hue
//   and output valid. No clearing pass is needed.
`include "hsv_pixel_frame_generator_unit_defines.svh"

module hsv_pixel_frame_generator_unit #(
    parameter int PIXEL_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue[8:0], saturation[15:9], brightness[22:16], zero pad
    input  logic        s_tuser,   // req_type: 0 solid colour, 1 rainbow tick
    // Pixel channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22], pad
    output logic        m_tlast    // last_pixel
);

    localparam logic [hsvpfg_pkg::IDX_W-1:0] LAST_IDX =
        hsvpfg_pkg::IDX_W'(PIXEL_COUNT - 1);

    hsvpfg_pkg::seq_ctl_t ctl;
    hsvpfg_pkg::pixel_t   pix;
    logic                 slot_free;

    // Output register state
    logic                              m_tvalid_reg;
    logic [hsvpfg_pkg::IDX_W-1:0]      idx_reg;
    logic [hsvpfg_pkg::CH_W-1:0]       red_reg, green_reg, blue_reg;
    logic                              last_reg;

    // The output register frees its slot when empty or being drained this cycle,
    // so the sequencer may refill it in the same cycle a transaction completes.
    assign slot_free = !m_tvalid_reg || m_tready;

    // Sequencer: steps the control store, takes requests and counts pixels
    hsvpfg_sequencer #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_tick   (s_tuser),
        .slot_free (slot_free),
        .in_ready  (s_tready),
        .ctl       (ctl)
    );

    // Datapath: clamps the request, runs the conversion steps, picks channels
    hsvpfg_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .in_hue  (s_tdata[8:0]),
        .in_sat  (s_tdata[15:9]),
        .in_val  (s_tdata[22:16]),
        .pix     (pix)
    );

    // Hold the valid flag until the transaction completes; load on an emit step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Payload: no reset, qualified by the valid flag
    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            idx_reg   <= ctl.pix_idx;
            red_reg   <= pix.red;
            green_reg <= pix.green;
            blue_reg  <= pix.blue;
            last_reg  <= ctl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, blue_reg, green_reg, red_reg, idx_reg};
    assign m_tlast  = last_reg;

    // The frame's final pixel carries the last index
    `ASSERT_IMPLIES(a_last_index, aclk, aresetn, m_tvalid && m_tlast, m_tdata[5:0] == LAST_IDX)
    // A pending pixel is never overwritten by a new emit
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, ctl.emit && m_tvalid_reg, m_tready)
    // Once a request is taken the block is busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule
